// File: hw/rtl/mmat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmat_pkg: shared definitions of the moving average threshold core
// Field widths, parameter defaults, controller states and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mmat_pkg;

    // Defaults for the top level parameters.
    localparam int FILTER_LENGTH_DEF = 8;
    localparam int CHANNELS_DEF      = 5;

    // Fixed field widths.
    localparam int SAMPLE_BITS = 10;
    localparam int CHANNEL_W   = 3;
    localparam int THRESH_W    = 10;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd512;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } mmat_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic update;
        logic div_step;
        logic finish;
    } mmat_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_range;
        logic div_last;
    } mmat_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/mmat_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmat_ram: generic single port RAM
// One access per cycle, either a write or a read; read data is registered.
// ----------------------------------------------------------------------------
module mmat_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 40,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: hw/rtl/mmat_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmat_datapath: per-channel filter state, sample ring, divider and result
// Holds the running sums, ring positions, fill counts and latest averages,
// the bit-serial divider and the result register.
// ----------------------------------------------------------------------------
module mmat_datapath #(
    parameter int FILTER_LENGTH = mmat_pkg::FILTER_LENGTH_DEF,
    parameter int CHANNELS      = mmat_pkg::CHANNELS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mmat_pkg::mmat_cmd_t               cmd,
    output mmat_pkg::mmat_status_t                 status,
    input  wire logic [mmat_pkg::CHANNEL_W-1:0]    channel,
    input  wire logic [mmat_pkg::SAMPLE_BITS-1:0]  sample,
    input  wire logic                              threshold_we,
    input  wire logic [mmat_pkg::THRESH_W-1:0]     threshold_wdata,
    output logic      [mmat_pkg::CHANNEL_W-1:0]    out_channel,
    output logic      [mmat_pkg::SAMPLE_BITS-1:0]  average,
    output logic                                   on_line,
    output logic      [CHANNELS-1:0]               pattern
);

    localparam int SB     = mmat_pkg::SAMPLE_BITS;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W  = (FILTER_LENGTH > 1) ? $clog2(FILTER_LENGTH) : 1;
    localparam int FILL_W = $clog2(FILTER_LENGTH + 1);
    localparam int SUM_W  = SB + $clog2(FILTER_LENGTH);
    localparam int CNT_W  = $clog2(SUM_W);
    localparam int DEPTH  = CHANNELS * FILTER_LENGTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Per-channel state.
    logic [POS_W-1:0]  pos_reg  [CHANNELS];
    logic [FILL_W-1:0] fill_reg [CHANNELS];
    logic [SUM_W-1:0]  sum_reg  [CHANNELS];
    logic [SB-1:0]     avg_reg  [CHANNELS];

    logic [mmat_pkg::THRESH_W-1:0] thr_reg;

    // Captured request.
    logic [CH_W-1:0] ch_reg;
    logic [SB-1:0]   smp_reg;

    // Divider.
    logic [SUM_W-1:0]  dvd_reg;
    logic [FILL_W-1:0] dvs_reg;
    logic [FILL_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // Result register.
    logic [mmat_pkg::CHANNEL_W-1:0] out_channel_reg;
    logic [SB-1:0]                  average_reg;
    logic                           on_line_reg;
    logic [CHANNELS-1:0]            pattern_reg;

    logic [POS_W-1:0]  cur_pos;
    logic [FILL_W-1:0] cur_fill;
    logic [SUM_W-1:0]  cur_sum;
    logic              full;
    logic [ADDR_W-1:0] ram_addr;
    logic [SB-1:0]     ram_rdata;
    logic [SB-1:0]     old_sample;
    logic [SUM_W-1:0]  sum_next;
    logic [POS_W-1:0]  pos_next;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W:0]   trial;
    logic              trial_ge;
    logic [FILL_W-1:0] rem_next;
    logic [SB-1:0]     avg_next;
    logic [CHANNELS-1:0] pattern_next;

    assign status.in_range = ({1'b0, channel} < (mmat_pkg::CHANNEL_W + 1)'(CHANNELS));
    assign status.div_last = (cnt_reg == CNT_W'(SUM_W - 1));

    assign cur_pos  = pos_reg[ch_reg];
    assign cur_fill = fill_reg[ch_reg];
    assign cur_sum  = sum_reg[ch_reg];
    assign full     = (cur_fill == FILL_W'(FILTER_LENGTH));
    assign ram_addr = ADDR_W'(ch_reg * FILTER_LENGTH + cur_pos);

    // During warm-up the slot being replaced was never written, so its value is taken as zero.
    assign old_sample = full ? ram_rdata : '0;
    assign sum_next   = cur_sum - SUM_W'(old_sample) + SUM_W'(smp_reg);
    assign pos_next   = (cur_pos == POS_W'(FILTER_LENGTH - 1)) ? '0 : cur_pos + 1'b1;
    assign fill_next  = full ? cur_fill : cur_fill + 1'b1;

    // One restoring division step; quotient bits shift in behind the dividend.
    assign trial    = {rem_reg, dvd_reg[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});
    assign rem_next = trial_ge ? FILL_W'(trial - {1'b0, dvs_reg}) : trial[FILL_W-1:0];

    assign avg_next = dvd_reg[SB-1:0];

    always_comb
    begin
        logic [SB-1:0] a;
        for (int i = 0; i < CHANNELS; i++)
        begin
            a = (CH_W'(i) == ch_reg) ? avg_next : avg_reg[i];
            pattern_next[CHANNELS-1-i] = (a < thr_reg);
        end
    end

    mmat_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ring (
        .clk  (clk),
        .en   (cmd.read | cmd.update),
        .we   (cmd.update),
        .addr (ram_addr),
        .wdata(smp_reg),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i]  <= '0;
                fill_reg[i] <= '0;
                sum_reg[i]  <= '0;
                avg_reg[i]  <= '0;
            end
            thr_reg <= mmat_pkg::THRESH_RESET;
            cnt_reg <= '0;
        end
        else
        begin
            if (threshold_we)
            begin
                thr_reg <= threshold_wdata;
            end
            if (cmd.update)
            begin
                sum_reg[ch_reg]  <= sum_next;
                pos_reg[ch_reg]  <= pos_next;
                fill_reg[ch_reg] <= fill_next;
                cnt_reg          <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                avg_reg[ch_reg] <= avg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg  <= channel[CH_W-1:0];
            smp_reg <= sample;
        end
        if (cmd.update)
        begin
            dvd_reg <= sum_next;
            dvs_reg <= fill_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], trial_ge};
            rem_reg <= rem_next;
        end
        if (cmd.finish)
        begin
            out_channel_reg <= mmat_pkg::CHANNEL_W'(ch_reg);
            average_reg     <= avg_next;
            on_line_reg     <= (avg_next < thr_reg);
            pattern_reg     <= pattern_next;
        end
    end

    assign out_channel = out_channel_reg;
    assign average     = average_reg;
    assign on_line     = on_line_reg;
    assign pattern     = pattern_reg;

endmodule
`default_nettype wire

// File: hw/rtl/mmat_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmat_controller: sequencing of one request through the datapath
// Accepts a request, steps read, update and divide, then loads the result
// register when it is free and tracks the result handshake.
// ----------------------------------------------------------------------------
module mmat_controller (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    input  wire mmat_pkg::mmat_status_t status,
    output mmat_pkg::mmat_cmd_t         cmd
);

    mmat_pkg::mmat_state_t state_reg;
    mmat_pkg::mmat_state_t state_next;
    logic                  result_valid_reg;
    logic                  result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mmat_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg & ~result_ready;
        sample_ready      = 1'b0;
        cmd               = '0;
        case (state_reg)
            mmat_pkg::ST_IDLE:
            begin
                sample_ready = 1'b1;
                // Requests for a channel that does not exist are taken and dropped.
                if (sample_valid && status.in_range)
                begin
                    cmd.capture = 1'b1;
                    state_next  = mmat_pkg::ST_READ;
                end
            end
            mmat_pkg::ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = mmat_pkg::ST_UPDATE;
            end
            mmat_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = mmat_pkg::ST_DIVIDE;
            end
            mmat_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = mmat_pkg::ST_FINISH;
                end
            end
            mmat_pkg::ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.finish        = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = mmat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmat_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;

endmodule
`default_nettype wire

// File: hw/rtl/multichannel_moving_average_threshold_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_moving_average_threshold_core: per-channel moving average core
// Averages the last FILTER_LENGTH samples of each sensor channel and flags
// the channels whose average lies below a programmable threshold.
// ----------------------------------------------------------------------------
// Each request carries one converter sample and its channel number. The core
// keeps, for every channel, a ring of the last FILTER_LENGTH samples in a
// single-port RAM together with a running sum, a ring position and a fill
// count, and it returns one result per request with the new truncated average
// of that channel, its on-line flag (average below the programmed threshold)
// and the flags of all channels, channel 0 in the most significant bit of
// pattern.
// During warm-up the average divides by the number of samples seen so far.
// A request with a channel number of CHANNELS or more is accepted and dropped
// without a result. After acceptance a request reads the oldest ring entry,
// updates the sum and writes the ring, runs the bit-serial divider over the
// running sum, whose width is SUM_W = 10 + clog2(FILTER_LENGTH), and loads
// the result register once no earlier result still waits untaken. The core
// accepts no new request until the result register is loaded, and the next
// request is taken while a result still waits. The threshold is written
// through threshold_we and threshold_wdata; the user must write it only while
// the core is idle, as the core itself does not enforce this. It resets to
// 512. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module multichannel_moving_average_threshold_core #(
    parameter int FILTER_LENGTH = mmat_pkg::FILTER_LENGTH_DEF,
    parameter int CHANNELS      = mmat_pkg::CHANNELS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Sample request channel.
    input  wire logic                              sample_valid,
    output logic                                   sample_ready,
    input  wire logic [mmat_pkg::CHANNEL_W-1:0]    channel,
    input  wire logic [mmat_pkg::SAMPLE_BITS-1:0]  sample,
    // Result request channel.
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic      [mmat_pkg::CHANNEL_W-1:0]    out_channel,
    output logic      [mmat_pkg::SAMPLE_BITS-1:0]  average,
    output logic                                   on_line,
    output logic      [CHANNELS-1:0]               pattern,
    // Threshold register write port.
    input  wire logic                              threshold_we,
    input  wire logic [mmat_pkg::THRESH_W-1:0]     threshold_wdata
);

    mmat_pkg::mmat_cmd_t    cmd;
    mmat_pkg::mmat_status_t status;

    // The controller sequences the request; the datapath holds the filter state and the result.
    mmat_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .status      (status),
        .cmd         (cmd)
    );

    mmat_datapath #(
        .FILTER_LENGTH(FILTER_LENGTH),
        .CHANNELS     (CHANNELS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .channel        (channel),
        .sample         (sample),
        .threshold_we   (threshold_we),
        .threshold_wdata(threshold_wdata),
        .out_channel    (out_channel),
        .average        (average),
        .on_line        (on_line),
        .pattern        (pattern)
    );

endmodule
`default_nettype wire
